// ----- sv/sync_length_checksum_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_macros
// Assertion macros shared by the deframer checker
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SLCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SLCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants of the sync / length / checksum deframer
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned CHECK_BYTES = 4;
    localparam int unsigned CHECK_W     = BYTE_W * CHECK_BYTES;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    // shortest accepted length: type byte plus checksum
    localparam logic [BYTE_W-1:0] MIN_LENGTH = BYTE_W'(CHECK_BYTES + 1);

    localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd250;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_VALUE   = 1'b0,
        REG_LENGTH_LIMIT = 1'b1
    } cfg_reg_t;

    // parser phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // per-item result status
    typedef enum logic [STATUS_W-1:0] {
        ST_NONE = 2'd0,
        ST_GOOD = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

endpackage

// ----- sv/sync_length_checksum_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Byte-wise frame parser: sync, length, type, payload, 32-bit sum checksum
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result per item.
// The block accepts a byte every cycle while s_ready is high: the parser state
// (phase, counters, 16-bit running sum and checksum shift register) is updated
// once per accepted byte, and the result lands in an output register in the
// cycle after acceptance. s_ready stays high while the output register is empty
// or being drained, so a stalled consumer costs no throughput beyond its own
// stall. Configuration writes take effect at the next clock edge.
module sync_length_checksum_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wen,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // received byte channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]         s_rx_byte,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [slcd_pkg::STATUS_W-1:0]       m_frame_status,
    output logic [slcd_pkg::BYTE_W-1:0]         m_frame_type
);

    slcd_pkg::phase_t                   phase_reg, phase_next;
    logic [slcd_pkg::BYTE_W-1:0]        sync_reg, limit_reg;
    logic [slcd_pkg::BYTE_W-1:0]        length_reg, length_next;
    logic [slcd_pkg::BYTE_W-1:0]        seen_reg, seen_next;
    logic [slcd_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [slcd_pkg::BYTE_W-1:0]        type_reg, type_next;
    logic [slcd_pkg::CHECK_W-1:0]       check_reg, check_next;

    logic                               valid_reg;
    slcd_pkg::status_t                  status_reg, status_next;
    logic [slcd_pkg::BYTE_W-1:0]        ftype_reg, ftype_next;

    logic                               accept;
    logic [slcd_pkg::BYTE_W-1:0]        seen_inc;
    logic [slcd_pkg::CHECK_W-1:0]       check_shift;
    logic                               in_payload;
    logic                               frame_done;
    logic                               len_ok;

    assign s_ready        = !valid_reg || m_ready;
    assign accept         = s_valid && s_ready;
    assign m_valid        = valid_reg;
    assign m_frame_status = status_reg;
    assign m_frame_type   = ftype_reg;

    // shared terms of the length and data phases
    assign seen_inc    = seen_reg + 8'd1;
    assign check_shift = {s_rx_byte, check_reg[slcd_pkg::CHECK_W-1:slcd_pkg::BYTE_W]};
    assign in_payload  = ({1'b0, seen_inc} + 9'(slcd_pkg::CHECK_BYTES)) <= {1'b0, length_reg};
    assign frame_done  = (seen_inc == length_reg);
    assign len_ok      = (s_rx_byte < limit_reg);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            slcd_pkg::PH_LEN: begin
                if (len_ok) begin
                    phase_next = (s_rx_byte < slcd_pkg::MIN_LENGTH) ?
                                 slcd_pkg::PH_HUNT : slcd_pkg::PH_DATA;
                end
            end
            slcd_pkg::PH_DATA: begin
                if (frame_done) begin
                    phase_next = slcd_pkg::PH_HUNT;
                end
            end
            default: begin
                phase_next = (s_rx_byte == sync_reg) ? slcd_pkg::PH_LEN : slcd_pkg::PH_HUNT;
            end
        endcase
    end

    // datapath and result for the accepted byte
    always_comb begin
        length_next = length_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        check_next  = check_reg;
        status_next = slcd_pkg::ST_NONE;
        ftype_next  = '0;
        unique case (phase_reg)
            slcd_pkg::PH_LEN: begin
                if (len_ok) begin
                    if (s_rx_byte < slcd_pkg::MIN_LENGTH) begin
                        length_next = '0;
                        seen_next   = '0;
                        sum_next    = '0;
                        type_next   = '0;
                        check_next  = '0;
                    end else begin
                        length_next = s_rx_byte;
                        sum_next    = sum_reg + slcd_pkg::SUM_W'(s_rx_byte);
                        seen_next   = '0;
                        check_next  = '0;
                    end
                end
            end
            slcd_pkg::PH_DATA: begin
                seen_next = seen_inc;
                if (seen_inc == 8'd1) begin
                    type_next = s_rx_byte;
                end
                if (in_payload) begin
                    sum_next = sum_reg + slcd_pkg::SUM_W'(s_rx_byte);
                end else begin
                    check_next = check_shift;
                end
                if (frame_done) begin
                    // compare uses this byte's updated checksum and sum
                    status_next = (check_next == slcd_pkg::CHECK_W'(sum_next)) ?
                                  slcd_pkg::ST_GOOD : slcd_pkg::ST_BAD;
                    ftype_next  = type_next;
                    length_next = '0;
                    seen_next   = '0;
                    sum_next    = '0;
                    type_next   = '0;
                    check_next  = '0;
                end
            end
            default: begin
                if (s_rx_byte == sync_reg) begin
                    length_next = '0;
                    seen_next   = '0;
                    sum_next    = slcd_pkg::SUM_W'(s_rx_byte);
                    type_next   = '0;
                    check_next  = '0;
                end
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg  <= slcd_pkg::SYNC_RESET;
            limit_reg <= slcd_pkg::LIMIT_RESET;
        end else if (cfg_wen) begin
            unique case (slcd_pkg::cfg_reg_t'(cfg_index))
                slcd_pkg::REG_SYNC_VALUE:   sync_reg  <= cfg_wdata;
                slcd_pkg::REG_LENGTH_LIMIT: limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= slcd_pkg::PH_HUNT;
            length_reg <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            type_reg   <= '0;
            check_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            check_reg  <= check_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            ftype_reg  <= ftype_next;
        end
    end

endmodule

// ----- sv/slcd_checker.sv -----
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level assertions for the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_macros.svh"

module slcd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [slcd_pkg::STATUS_W-1:0]       m_frame_status,
    input logic [slcd_pkg::BYTE_W-1:0]         m_frame_type
);

    // a held result keeps its payload
    `SLCD_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_frame_status) && $stable(m_frame_type), "result changed while stalled")

    // every accepted item produces a result next cycle
    `SLCD_ASSERT_NEXT(a_result, s_valid && s_ready, m_valid, "accepted item gave no result")

    // input is never blocked when the output can move
    `SLCD_ASSERT_NOW(a_flow, !m_valid || m_ready, s_ready, "input stalled with free output")

    // no completed frame means no type and no unused status code
    `SLCD_ASSERT_NOW(a_type, m_valid && (m_frame_status != slcd_pkg::ST_GOOD) && (m_frame_status != slcd_pkg::ST_BAD), (m_frame_status == slcd_pkg::ST_NONE) && (m_frame_type == '0), "bad status or stray type")

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

// ----- bench/tb_sync_length_checksum_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_sync_length_checksum_deframer
// Self-checking bench for the sync / length / checksum deframer
// ----------------------------------------------------------------------------
// A short table of directed bytes walks through the hunt, rejected and short
// lengths, a good frame, a bad checksum and a sync byte inside a frame. Random
// phases follow, each under its own register setting, made mostly of
// well-formed frames with random payload, plus corrupted checksums, truncated
// frames, bad lengths and line noise. A local parser model predicts the
// status and type of every accepted item, and each result is checked in order
// against it. Either side may idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_sync_length_checksum_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LATENCY     = 1;
    localparam int unsigned N_DIRECTED  = 28;

    typedef struct packed {
        slcd_pkg::status_t           status;
        logic [slcd_pkg::BYTE_W-1:0] ftype;
    } frame_result_t;

    typedef struct packed {
        logic [slcd_pkg::BYTE_W-1:0] rx;
        logic                        typed;
        slcd_pkg::status_t           status;
        logic [slcd_pkg::BYTE_W-1:0] ftype;
    } directed_row_t;

    typedef struct packed {
        slcd_pkg::phase_t             phase;
        logic [slcd_pkg::BYTE_W-1:0]  frame_len;
        logic [slcd_pkg::BYTE_W-1:0]  seen;
        logic [slcd_pkg::SUM_W-1:0]   sum;
        logic [slcd_pkg::BYTE_W-1:0]  type_latch;
        logic [slcd_pkg::CHECK_W-1:0] check;
    } parser_state_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wen;
    logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [slcd_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [slcd_pkg::BYTE_W-1:0]     s_rx_byte;
    logic                            m_valid;
    logic                            m_ready;
    logic [slcd_pkg::STATUS_W-1:0]   m_frame_status;
    logic [slcd_pkg::BYTE_W-1:0]     m_frame_type;

    // model copy of the parser and its registers
    parser_state_t               parser;
    logic [slcd_pkg::BYTE_W-1:0] model_sync;
    logic [slcd_pkg::BYTE_W-1:0] model_limit;

    frame_result_t               pending_results[$];
    logic [slcd_pkg::BYTE_W-1:0] rx_stream[$];

    bit          src_idle;
    bit          sink_idle;
    int unsigned fail_count;
    int unsigned cycle_count;

    // hunt, rejected and short lengths, good frame, bad checksum, sync in frame
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'hFF, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'h55, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'hFA, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'h04, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'h55, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h05, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h07, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h61, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b1, slcd_pkg::ST_GOOD, 8'h07},
        '{8'h55, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h05, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'hFF, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h59, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h01, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h01, 1'b1, slcd_pkg::ST_BAD,  8'hFF},
        '{8'h55, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'hFF, 1'b1, slcd_pkg::ST_NONE, 8'h00},
        '{8'h06, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h55, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'hB0, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b0, slcd_pkg::ST_NONE, 8'h00},
        '{8'h00, 1'b1, slcd_pkg::ST_GOOD, 8'h55}
    };

    sync_length_checksum_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_frame_type   (m_frame_type)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter and watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // back to hunting with everything cleared
    function automatic void clear_parser();
        parser.phase      = slcd_pkg::PH_HUNT;
        parser.frame_len  = '0;
        parser.seen       = '0;
        parser.sum        = '0;
        parser.type_latch = '0;
        parser.check      = '0;
    endfunction

    // advance the model parser by one byte and return that item's result
    function automatic frame_result_t advance_parser(logic [slcd_pkg::BYTE_W-1:0] b);
        frame_result_t               r;
        logic [slcd_pkg::BYTE_W-1:0] cnt;
        r.status = slcd_pkg::ST_NONE;
        r.ftype  = '0;
        case (parser.phase)
            slcd_pkg::PH_LEN: begin
                if (b < model_limit) begin
                    if (b < slcd_pkg::MIN_LENGTH) begin
                        clear_parser();
                    end else begin
                        parser.frame_len = b;
                        parser.sum       = parser.sum + slcd_pkg::SUM_W'(b);
                        parser.seen      = '0;
                        parser.check     = '0;
                        parser.phase     = slcd_pkg::PH_DATA;
                    end
                end
            end
            slcd_pkg::PH_DATA: begin
                cnt         = parser.seen + 1'b1;
                parser.seen = cnt;
                if (cnt == 8'd1)
                    parser.type_latch = b;
                // payload bytes are summed, the trailing four shift into the checksum
                if (int'(cnt) + int'(slcd_pkg::CHECK_BYTES) <= int'(parser.frame_len))
                    parser.sum = parser.sum + slcd_pkg::SUM_W'(b);
                else
                    parser.check = {b, parser.check[slcd_pkg::CHECK_W-1:slcd_pkg::BYTE_W]};
                if (cnt == parser.frame_len) begin
                    r.status = (parser.check == slcd_pkg::CHECK_W'(parser.sum)) ?
                               slcd_pkg::ST_GOOD : slcd_pkg::ST_BAD;
                    r.ftype  = parser.type_latch;
                    clear_parser();
                end
            end
            default: begin
                if (b == model_sync) begin
                    clear_parser();
                    parser.sum   = slcd_pkg::SUM_W'(b);
                    parser.phase = slcd_pkg::PH_LEN;
                end
            end
        endcase
        return r;
    endfunction

    // offer one byte, wait for acceptance, then record its expected result
    task automatic send_byte(logic [slcd_pkg::BYTE_W-1:0] b, bit typed, frame_result_t given);
        frame_result_t predicted;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_parser(b);
        pending_results.push_back(typed ? given : predicted);
    endtask

    task automatic send_stream();
        frame_result_t unused;
        unused = '0;
        while (rx_stream.size() > 0)
            send_byte(rx_stream.pop_front(), 1'b0, unused);
        s_valid <= 1'b0;
    endtask

    // wait until every expected result is back, plus the block's latency
    task automatic drain();
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_config(logic [slcd_pkg::BYTE_W-1:0] sync_byte,
                              logic [slcd_pkg::BYTE_W-1:0] limit);
        cfg_wen   <= 1'b1;
        cfg_index <= slcd_pkg::REG_SYNC_VALUE;
        cfg_wdata <= sync_byte;
        @(posedge aclk);
        cfg_index <= slcd_pkg::REG_LENGTH_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_wen     <= 1'b0;
        model_sync  = sync_byte;
        model_limit = limit;
    endtask

    // append one random frame, broken frame or noise burst to the stream
    task automatic add_frame();
        int unsigned                  kind;
        int unsigned                  len;
        int unsigned                  hi;
        int unsigned                  cut;
        logic [slcd_pkg::BYTE_W-1:0]  b;
        logic [slcd_pkg::SUM_W-1:0]   sum;
        logic [slcd_pkg::CHECK_W-1:0] chk;
        logic [slcd_pkg::BYTE_W-1:0]  payload[$];
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 4)) rx_stream.push_back(slcd_pkg::BYTE_W'($urandom));
            return;
        end
        rx_stream.push_back(model_sync);
        sum = slcd_pkg::SUM_W'(model_sync);
        // lengths at or above the limit are skipped
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2))
                rx_stream.push_back(slcd_pkg::BYTE_W'($urandom_range(model_limit, 255)));
        // short length, or no long length allowed at this limit
        if (kind < 16 || model_limit <= slcd_pkg::MIN_LENGTH) begin
            rx_stream.push_back(slcd_pkg::BYTE_W'($urandom_range(0, slcd_pkg::MIN_LENGTH - 1)));
            return;
        end
        hi = model_limit - 1;
        if ($urandom_range(0, 29) == 0)
            len = ($urandom_range(0, 1) == 0) ? hi : $urandom_range(slcd_pkg::MIN_LENGTH, hi);
        else
            len = $urandom_range(slcd_pkg::MIN_LENGTH, (hi < 20) ? hi : 20);
        rx_stream.push_back(slcd_pkg::BYTE_W'(len));
        sum = sum + slcd_pkg::SUM_W'(len);
        for (int i = 0; i < int'(len - slcd_pkg::CHECK_BYTES); i++) begin
            b = ($urandom_range(0, 15) == 0) ? model_sync : slcd_pkg::BYTE_W'($urandom);
            payload.push_back(b);
            sum = sum + slcd_pkg::SUM_W'(b);
        end
        chk = slcd_pkg::CHECK_W'(sum);
        if ($urandom_range(0, 4) == 0)
            chk = chk ^ (slcd_pkg::CHECK_W'(1) << $urandom_range(0, slcd_pkg::CHECK_W - 1));
        for (int i = 0; i < int'(slcd_pkg::CHECK_BYTES); i++)
            payload.push_back(chk[i*slcd_pkg::BYTE_W +: slcd_pkg::BYTE_W]);
        // a truncated frame lets the following bytes run into it
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < int'(cut); i++)
            rx_stream.push_back(payload[i]);
    endtask

    task automatic run_random(int unsigned n_items);
        while (rx_stream.size() < n_items) add_frame();
        send_stream();
        drain();
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: status %0d type 0x%02h",
                             m_frame_status, m_frame_type);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_frame_status !== want.status || m_frame_type !== want.ftype) begin
                    if (fail_count < 10)
                        $display("mismatch: status exp %0d got %0d, type exp 0x%02h got 0x%02h",
                                 want.status, m_frame_status, want.ftype, m_frame_type);
                    fail_count++;
                end
            end
        end
    end

    // result side stalls
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // main sequence
    initial begin
        frame_result_t given;
        fail_count = 0;
        src_idle   = 1'b1;
        sink_idle  = 1'b1;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= slcd_pkg::REG_SYNC_VALUE;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        model_sync  = slcd_pkg::SYNC_RESET;
        model_limit = slcd_pkg::LIMIT_RESET;
        clear_parser();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under reset settings
        for (int i = 0; i < int'(N_DIRECTED); i++) begin
            given.status = directed_rows[i].status;
            given.ftype  = directed_rows[i].ftype;
            send_byte(directed_rows[i].rx, directed_rows[i].typed, given);
        end
        s_valid <= 1'b0;
        drain();

        // random phases across register settings
        run_random(220);

        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        set_config(8'h00, 8'hFF);
        run_random(260);

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        set_config(8'hFF, slcd_pkg::MIN_LENGTH);
        run_random(100);

        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        set_config(slcd_pkg::BYTE_W'($urandom),
                   slcd_pkg::BYTE_W'($urandom_range(slcd_pkg::MIN_LENGTH + 1, 255)));
        run_random(260);

        // last part runs without idling
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_config(slcd_pkg::BYTE_W'($urandom), slcd_pkg::LIMIT_RESET);
        run_random(260);

        repeat (LATENCY + 8) @(posedge aclk);
        fail_count += pending_results.size();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
